>>> rtl/core/fomps_pkg.sv
`timescale 1ns / 1ps

package fomps_pkg;

    localparam logic [1:0] KIND_ARRIVE = 2'd0;
    localparam logic [1:0] KIND_OLDEST = 2'd1;
    localparam logic [1:0] KIND_BEST   = 2'd2;

    localparam logic [1:0] STATUS_SERVED = 2'd0;
    localparam logic [1:0] STATUS_EMPTY  = 2'd1;
    localparam logic [1:0] STATUS_FULL   = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_OLD_RD,
        ST_OLD_CHK,
        ST_BEST_RD,
        ST_BEST_CHK,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic insert;
        logic pop;
    } chain_ctrl_t;

endpackage

>>> rtl/core/fomps_if.sv
`timescale 1ns / 1ps

interface fomps_in_if #(
    parameter int VALUE_BITS = 20
);
    logic                  valid;
    logic                  ready;
    logic [1:0]            kind;
    logic [VALUE_BITS-1:0] priority_value;

    modport source (output valid, output kind, output priority_value, input ready);
    modport sink (input valid, input kind, input priority_value, output ready);
endinterface

interface fomps_out_if #(
    parameter int NUMBER_BITS = 11
);
    logic                   valid;
    logic                   ready;
    logic [NUMBER_BITS-1:0] served_number;
    logic [1:0]             status;

    modport source (output valid, output served_number, output status, input ready);
    modport sink (input valid, input served_number, input status, output ready);
endinterface

>>> rtl/core/fifo_or_max_priority_server_unit.sv
`timescale 1ns / 1ps

// Waiting queue with two service policies over one pool of entries.
// The input channel carries a kind and a priority value. An arrival takes the
// next arrival number and produces no output transfer; a serve-oldest request
// returns the lowest unserved number, a serve-best request the unserved entry
// with the largest value, the lower number winning on equal values.
// The output channel carries the served number and a status: served, nothing
// waiting, or arrival dropped because all numbers are used. Kind 3 is ignored.
// Entries sit in a row of cells kept sorted best first; a new entry is inserted
// in order, and a served entry is popped off the head. A one-bit served memory
// indexed by arrival number marks served entries; entries served by the other
// policy are skipped, each skip repeating the registered read and its check.
// Sequence: an arrival is taken in the idle state. A serve passes a read state
// and a check state, both repeated per skipped entry, then the emit state loads
// the output register, and the next input is taken back in the idle state; a
// nothing-waiting or dropped-arrival result goes from idle to the emit state.
// Reset clears the counters, the output valid bit and the valid bits of the
// cells; no clearing pass is needed, and items are taken right after reset.
// Arrivals are taken while a result waits in the output register; a result
// that is ready while the receiver stalls waits, and then input is held off.

module fifo_or_max_priority_server_unit #(
    parameter int CAPACITY   = 1024,
    parameter int VALUE_BITS = 20
) (
    input  logic        clk,
    input  logic        rst_n,
    fomps_in_if.sink    in_ch,
    fomps_out_if.source out_ch
);

    localparam int IDX_BITS = $clog2(CAPACITY);
    localparam int NUM_BITS = $clog2(CAPACITY + 1);

    fomps_pkg::state_t      state_reg;
    fomps_pkg::state_t      state_next;
    fomps_pkg::chain_ctrl_t ctrl;

    logic [NUM_BITS-1:0] arrived_reg;
    logic [NUM_BITS-1:0] arrived_next;
    logic [NUM_BITS-1:0] waiting_reg;
    logic [NUM_BITS-1:0] waiting_next;
    logic [IDX_BITS-1:0] ptr_reg;
    logic [IDX_BITS-1:0] ptr_next;
    logic [NUM_BITS-1:0] res_num_reg;
    logic [NUM_BITS-1:0] res_num_next;
    logic [1:0]          res_status_reg;
    logic [1:0]          res_status_next;
    logic                out_valid_reg;
    logic [NUM_BITS-1:0] out_num_reg;
    logic [1:0]          out_status_reg;
    logic                out_load;

    logic                served_mem [CAPACITY];
    logic                served_rd_reg;
    logic                mem_we;
    logic [IDX_BITS-1:0] mem_waddr;
    logic                mem_wdata;
    logic [IDX_BITS-1:0] mem_raddr;

    logic                head_valid;
    logic [IDX_BITS-1:0] head_idx;
    logic                accept;
    logic                full;
    logic                slot_free;

    assign in_ch.ready = (state_reg == fomps_pkg::ST_IDLE);
    assign accept      = in_ch.valid && in_ch.ready;
    assign full        = (arrived_reg == NUM_BITS'(CAPACITY));
    assign slot_free   = !out_valid_reg || out_ch.ready;
    assign mem_raddr   = (state_reg == fomps_pkg::ST_BEST_RD) ? head_idx : ptr_reg;

    fomps_chain #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS),
        .IDX_BITS   (IDX_BITS)
    ) u_chain (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .new_idx    (arrived_reg[IDX_BITS-1:0]),
        .new_val    (in_ch.priority_value),
        .head_valid (head_valid),
        .head_idx   (head_idx)
    );

    always_comb
    begin
        state_next      = state_reg;
        arrived_next    = arrived_reg;
        waiting_next    = waiting_reg;
        ptr_next        = ptr_reg;
        res_num_next    = res_num_reg;
        res_status_next = res_status_reg;
        ctrl            = '0;
        mem_we          = 1'b0;
        mem_waddr       = ptr_reg;
        mem_wdata       = 1'b0;
        out_load        = 1'b0;
        case (state_reg)
            fomps_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (in_ch.kind)
                        fomps_pkg::KIND_ARRIVE:
                        begin
                            if (full)
                            begin
                                res_num_next    = '0;
                                res_status_next = fomps_pkg::STATUS_FULL;
                                state_next      = fomps_pkg::ST_EMIT;
                            end
                            else
                            begin
                                ctrl.insert  = 1'b1;
                                mem_we       = 1'b1;
                                mem_waddr    = arrived_reg[IDX_BITS-1:0];
                                mem_wdata    = 1'b0;
                                arrived_next = arrived_reg + NUM_BITS'(1);
                                waiting_next = waiting_reg + NUM_BITS'(1);
                            end
                        end
                        fomps_pkg::KIND_OLDEST:
                        begin
                            if (waiting_reg == '0)
                            begin
                                res_num_next    = '0;
                                res_status_next = fomps_pkg::STATUS_EMPTY;
                                state_next      = fomps_pkg::ST_EMIT;
                            end
                            else
                            begin
                                state_next = fomps_pkg::ST_OLD_RD;
                            end
                        end
                        fomps_pkg::KIND_BEST:
                        begin
                            if (waiting_reg == '0)
                            begin
                                res_num_next    = '0;
                                res_status_next = fomps_pkg::STATUS_EMPTY;
                                state_next      = fomps_pkg::ST_EMIT;
                            end
                            else
                            begin
                                state_next = fomps_pkg::ST_BEST_RD;
                            end
                        end
                        default:
                        begin
                            state_next = fomps_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            fomps_pkg::ST_OLD_RD:
            begin
                state_next = fomps_pkg::ST_OLD_CHK;
            end
            fomps_pkg::ST_OLD_CHK:
            begin
                ptr_next = ptr_reg + IDX_BITS'(1);
                if (served_rd_reg)
                begin
                    state_next = fomps_pkg::ST_OLD_RD;
                end
                else
                begin
                    res_num_next    = NUM_BITS'(ptr_reg) + NUM_BITS'(1);
                    res_status_next = fomps_pkg::STATUS_SERVED;
                    mem_we          = 1'b1;
                    mem_waddr       = ptr_reg;
                    mem_wdata       = 1'b1;
                    waiting_next    = waiting_reg - NUM_BITS'(1);
                    state_next      = fomps_pkg::ST_EMIT;
                end
            end
            fomps_pkg::ST_BEST_RD:
            begin
                if (head_valid)
                begin
                    state_next = fomps_pkg::ST_BEST_CHK;
                end
                else
                begin
                    res_num_next    = '0;
                    res_status_next = fomps_pkg::STATUS_EMPTY;
                    state_next      = fomps_pkg::ST_EMIT;
                end
            end
            fomps_pkg::ST_BEST_CHK:
            begin
                ctrl.pop = 1'b1;
                if (served_rd_reg)
                begin
                    state_next = fomps_pkg::ST_BEST_RD;
                end
                else
                begin
                    res_num_next    = NUM_BITS'(head_idx) + NUM_BITS'(1);
                    res_status_next = fomps_pkg::STATUS_SERVED;
                    mem_we          = 1'b1;
                    mem_waddr       = head_idx;
                    mem_wdata       = 1'b1;
                    waiting_next    = waiting_reg - NUM_BITS'(1);
                    state_next      = fomps_pkg::ST_EMIT;
                end
            end
            fomps_pkg::ST_EMIT:
            begin
                if (slot_free)
                begin
                    out_load   = 1'b1;
                    state_next = fomps_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fomps_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fomps_pkg::ST_IDLE;
            arrived_reg   <= '0;
            waiting_reg   <= '0;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            arrived_reg <= arrived_next;
            waiting_reg <= waiting_next;
            ptr_reg     <= ptr_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_num_reg    <= res_num_next;
        res_status_reg <= res_status_next;
        if (out_load)
        begin
            out_num_reg    <= res_num_reg;
            out_status_reg <= res_status_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            served_mem[mem_waddr] <= mem_wdata;
        end
        served_rd_reg <= served_mem[mem_raddr];
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.served_number = out_num_reg;
    assign out_ch.status        = out_status_reg;

endmodule

>>> rtl/core/fomps_cell.sv
`timescale 1ns / 1ps

module fomps_cell #(
    parameter int IDX_BITS   = 10,
    parameter int VALUE_BITS = 20
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  fomps_pkg::chain_ctrl_t   ctrl,
    input  logic [IDX_BITS-1:0]      new_idx,
    input  logic [VALUE_BITS-1:0]    new_val,
    input  logic                     left_valid,
    input  logic [IDX_BITS-1:0]      left_idx,
    input  logic [VALUE_BITS-1:0]    left_val,
    input  logic                     left_goes,
    input  logic                     right_valid,
    input  logic [IDX_BITS-1:0]      right_idx,
    input  logic [VALUE_BITS-1:0]    right_val,
    output logic                     valid,
    output logic [IDX_BITS-1:0]      idx,
    output logic [VALUE_BITS-1:0]    val,
    output logic                     goes
);

    logic                  valid_reg;
    logic                  valid_next;
    logic [IDX_BITS-1:0]   idx_reg;
    logic [IDX_BITS-1:0]   idx_next;
    logic [VALUE_BITS-1:0] val_reg;
    logic [VALUE_BITS-1:0] val_next;

    // A new arrival always carries the largest number, so it loses every tie.
    assign goes = !valid_reg || (new_val > val_reg);

    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        val_next   = val_reg;
        if (ctrl.insert)
        begin
            if (left_goes)
            begin
                valid_next = left_valid;
                idx_next   = left_idx;
                val_next   = left_val;
            end
            else if (goes)
            begin
                valid_next = 1'b1;
                idx_next   = new_idx;
                val_next   = new_val;
            end
        end
        else if (ctrl.pop)
        begin
            valid_next = right_valid;
            idx_next   = right_idx;
            val_next   = right_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        val_reg <= val_next;
    end

    assign valid = valid_reg;
    assign idx   = idx_reg;
    assign val   = val_reg;

endmodule

>>> rtl/core/fomps_chain.sv
`timescale 1ns / 1ps

module fomps_chain #(
    parameter int CAPACITY   = 1024,
    parameter int VALUE_BITS = 20,
    parameter int IDX_BITS   = 10
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  fomps_pkg::chain_ctrl_t ctrl,
    input  logic [IDX_BITS-1:0]    new_idx,
    input  logic [VALUE_BITS-1:0]  new_val,
    output logic                   head_valid,
    output logic [IDX_BITS-1:0]    head_idx
);

    logic                  valid_w [CAPACITY];
    logic [IDX_BITS-1:0]   idx_w   [CAPACITY];
    logic [VALUE_BITS-1:0] val_w   [CAPACITY];
    logic                  goes_w  [CAPACITY];

    logic                  lv [CAPACITY];
    logic [IDX_BITS-1:0]   li [CAPACITY];
    logic [VALUE_BITS-1:0] lx [CAPACITY];
    logic                  lg [CAPACITY];
    logic                  rv [CAPACITY];
    logic [IDX_BITS-1:0]   ri [CAPACITY];
    logic [VALUE_BITS-1:0] rx [CAPACITY];

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        if (i == 0)
        begin : g_first
            assign lv[i] = 1'b0;
            assign li[i] = '0;
            assign lx[i] = '0;
            assign lg[i] = 1'b0;
        end
        else
        begin : g_mid_l
            assign lv[i] = valid_w[i-1];
            assign li[i] = idx_w[i-1];
            assign lx[i] = val_w[i-1];
            assign lg[i] = goes_w[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign rv[i] = 1'b0;
            assign ri[i] = '0;
            assign rx[i] = '0;
        end
        else
        begin : g_mid_r
            assign rv[i] = valid_w[i+1];
            assign ri[i] = idx_w[i+1];
            assign rx[i] = val_w[i+1];
        end

        fomps_cell #(
            .IDX_BITS   (IDX_BITS),
            .VALUE_BITS (VALUE_BITS)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .new_idx     (new_idx),
            .new_val     (new_val),
            .left_valid  (lv[i]),
            .left_idx    (li[i]),
            .left_val    (lx[i]),
            .left_goes   (lg[i]),
            .right_valid (rv[i]),
            .right_idx   (ri[i]),
            .right_val   (rx[i]),
            .valid       (valid_w[i]),
            .idx         (idx_w[i]),
            .val         (val_w[i]),
            .goes        (goes_w[i])
        );
    end

    assign head_valid = valid_w[0];
    assign head_idx   = idx_w[0];

endmodule

>>> rtl/core/fomps_checker.sv
`timescale 1ns / 1ps

module fomps_checker #(
    parameter int NUM_BITS = 11
) (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input logic [NUM_BITS-1:0] served_number,
    input logic [1:0]          status
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(served_number) && $stable(status))
        else $error("Stalled result changed before its transfer.");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != fomps_pkg::STATUS_SERVED |-> served_number == '0)
        else $error("Result without service carries a nonzero number.");

    a_served_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == fomps_pkg::STATUS_SERVED |-> served_number != '0)
        else $error("Served result carries number zero.");

    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_ready) |-> $past(in_valid))
        else $error("Input stopped being taken without a transfer.");

endmodule

bind fifo_or_max_priority_server_unit fomps_checker #(
    .NUM_BITS (NUM_BITS)
) u_fomps_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .served_number (out_ch.served_number),
    .status        (out_ch.status)
);

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    import fomps_pkg::*;

    localparam int CAPACITY    = 1024;
    localparam int VALUE_BITS  = 20;
    localparam int NUMBER_BITS = 11;
    localparam int IDLE_LIMIT  = 20000;
    localparam int LONG_HOLD   = 400;
    localparam int RANDOM_ITEMS = 740;
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam logic [VALUE_BITS-1:0] VALUE_MAX = '1;

    typedef struct packed {
        logic [NUMBER_BITS-1:0] number;
        logic [1:0]             status;
    } service_result_t;

    typedef struct packed {
        logic [1:0]            kind;
        logic [VALUE_BITS-1:0] value;
        logic                  fixed;
        service_result_t       want;
    } script_row_t;

    logic clk;
    logic rst_n;

    fomps_in_if #(.VALUE_BITS(VALUE_BITS)) req_ch ();
    fomps_out_if #(.NUMBER_BITS(NUMBER_BITS)) rsp_ch ();

    fifo_or_max_priority_server_unit #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (req_ch),
        .out_ch (rsp_ch)
    );

    int unsigned           issued_next = 1;
    int unsigned           scan_ptr = 0;
    bit                    taken [CAPACITY];
    logic [VALUE_BITS-1:0] entry_value [CAPACITY];
    int unsigned           rank_heap [CAPACITY];
    int unsigned           rank_count = 0;
    int unsigned           waiting_count = 0;

    service_result_t pending_services [$];
    script_row_t     script [$];
    int              mismatch_count = 0;
    int              results_seen = 0;
    int              burst_left = 0;
    bit              long_hold_done = 0;

    function automatic bit ranks_above(int unsigned a, int unsigned b);
        logic [VALUE_BITS-1:0] va;
        logic [VALUE_BITS-1:0] vb;
        va = entry_value[a % CAPACITY];
        vb = entry_value[b % CAPACITY];
        return (va > vb) || (va == vb && a < b);
    endfunction

    function automatic void rank_insert(int unsigned idx);
        int unsigned i;
        int unsigned p;
        int unsigned t;
        if (rank_count >= CAPACITY)
            return;
        i = rank_count;
        rank_count++;
        rank_heap[i] = idx;
        while (i > 0)
        begin
            p = (i - 1) / 2;
            if (!ranks_above(rank_heap[i], rank_heap[p]))
                break;
            t = rank_heap[i];
            rank_heap[i] = rank_heap[p];
            rank_heap[p] = t;
            i = p;
        end
    endfunction

    function automatic void rank_remove_top();
        int unsigned i;
        int unsigned l;
        int unsigned r;
        int unsigned top;
        int unsigned t;
        if (rank_count == 0)
            return;
        rank_count--;
        rank_heap[0] = rank_heap[rank_count];
        i = 0;
        while (1)
        begin
            l = 2 * i + 1;
            r = l + 1;
            top = i;
            if (l < rank_count && ranks_above(rank_heap[l], rank_heap[top]))
                top = l;
            if (r < rank_count && ranks_above(rank_heap[r], rank_heap[top]))
                top = r;
            if (top == i)
                break;
            t = rank_heap[i];
            rank_heap[i] = rank_heap[top];
            rank_heap[top] = t;
            i = top;
        end
    endfunction

    function automatic bit predict_service(input logic [1:0] kind,
                                           input logic [VALUE_BITS-1:0] value,
                                           output service_result_t res);
        int unsigned idx;
        res.number = '0;
        res.status = STATUS_EMPTY;
        case (kind)
            KIND_ARRIVE:
            begin
                if (issued_next > CAPACITY)
                begin
                    res.status = STATUS_FULL;
                    return 1;
                end
                idx = issued_next - 1;
                entry_value[idx] = value;
                taken[idx] = 0;
                rank_insert(idx);
                issued_next++;
                waiting_count++;
                return 0;
            end
            KIND_OLDEST:
            begin
                if (waiting_count == 0)
                    return 1;
                while (scan_ptr < CAPACITY && taken[scan_ptr])
                    scan_ptr++;
                if (scan_ptr >= CAPACITY)
                    return 1;
                taken[scan_ptr] = 1;
                waiting_count--;
                res.number = NUMBER_BITS'(scan_ptr + 1);
                res.status = STATUS_SERVED;
                return 1;
            end
            KIND_BEST:
            begin
                if (waiting_count == 0)
                    return 1;
                while (rank_count > 0 && taken[rank_heap[0] % CAPACITY])
                    rank_remove_top();
                if (rank_count == 0)
                    return 1;
                idx = rank_heap[0] % CAPACITY;
                rank_remove_top();
                taken[idx] = 1;
                waiting_count--;
                res.number = NUMBER_BITS'(idx + 1);
                res.status = STATUS_SERVED;
                return 1;
            end
            default:
                return 0;
        endcase
    endfunction

    function automatic script_row_t row(logic [1:0] kind, logic [VALUE_BITS-1:0] value,
                                        logic fixed, logic [NUMBER_BITS-1:0] number,
                                        logic [1:0] status);
        script_row_t r;
        r.kind = kind;
        r.value = value;
        r.fixed = fixed;
        r.want.number = number;
        r.want.status = status;
        return r;
    endfunction

    function automatic logic [1:0] pick_kind();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return KIND_ARRIVE;
        else if (roll < 72)
            return KIND_OLDEST;
        else if (roll < 96)
            return KIND_BEST;
        else
            return KIND_UNUSED;
    endfunction

    function automatic logic [VALUE_BITS-1:0] pick_value();
        int unsigned roll;
        roll = $urandom_range(0, 11);
        if (roll < 4)
            return VALUE_BITS'($urandom_range(0, 3));
        else if (roll == 4)
            return '0;
        else if (roll == 5)
            return VALUE_MAX;
        else
            return VALUE_BITS'($urandom);
    endfunction

    task automatic transfer_request(logic [1:0] kind, logic [VALUE_BITS-1:0] value,
                                    logic fixed, service_result_t want);
        service_result_t res;
        bit has_result;
        @(negedge clk);
        req_ch.valid <= 1'b1;
        req_ch.kind <= kind;
        req_ch.priority_value <= value;
        do
            @(posedge clk);
        while (!req_ch.ready);
        has_result = predict_service(kind, value, res);
        if (has_result)
            pending_services.insert(pending_services.size(), fixed ? want : res);
    endtask

    task automatic sender_pace();
        int unsigned gap;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            gap = $urandom_range(1, 6);
            @(negedge clk);
            req_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
            burst_left = ($urandom_range(0, 9) == 0) ? 60 : $urandom_range(1, 16);
        end
    endtask

    task automatic drain_expected();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (pending_services.size() != 0)
            @(posedge clk);
    endtask

    task automatic random_request();
        logic [1:0] kind;
        kind = pick_kind();
        transfer_request(kind, pick_value(), 1'b0, '0);
        sender_pace();
    endtask

    task automatic serve_request();
        logic [1:0] kind;
        kind = $urandom_range(0, 1) ? KIND_OLDEST : KIND_BEST;
        transfer_request(kind, pick_value(), 1'b0, '0);
        sender_pace();
    endtask

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        int unsigned mode;
        int unsigned tick;
        rsp_ch.ready = 1'b0;
        mode = 0;
        tick = 0;
        forever
        begin
            @(negedge clk);
            if (!long_hold_done && results_seen >= 40)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                long_hold_done = 1;
            end
            else
            begin
                tick++;
                if (tick % 64 == 0)
                    mode = $urandom_range(0, 3);
                case (mode)
                    0: rsp_ch.ready <= 1'b1;
                    1: rsp_ch.ready <= 1'($urandom_range(0, 1));
                    2: rsp_ch.ready <= (tick % 4 == 0);
                    default: rsp_ch.ready <= ($urandom_range(0, 4) != 0);
                endcase
            end
        end
    end

    initial
    begin
        service_result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
            begin
                results_seen++;
                if (pending_services.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected transfer: number %0d status %0d",
                                 rsp_ch.served_number, rsp_ch.status);
                end
                else
                begin
                    want = pending_services.pop_front();
                    if (rsp_ch.served_number !== want.number || rsp_ch.status !== want.status)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"mismatch: expected number %0d status %0d, ",
                                      "got number %0d status %0d"},
                                     want.number, want.status,
                                     rsp_ch.served_number, rsp_ch.status);
                    end
                end
            end
        end
    end

    initial
    begin
        int unsigned idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        req_ch.valid = 1'b0;
        req_ch.kind = KIND_ARRIVE;
        req_ch.priority_value = '0;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        script.insert(script.size(), row(KIND_OLDEST, '0, 1'b1, '0, STATUS_EMPTY));
        script.insert(script.size(), row(KIND_BEST, VALUE_MAX, 1'b1, '0, STATUS_EMPTY));
        script.insert(script.size(), row(KIND_UNUSED, VALUE_MAX, 1'b0, '0, STATUS_SERVED));
        script.insert(script.size(), row(KIND_ARRIVE, VALUE_MAX, 1'b0, '0, STATUS_SERVED));
        script.insert(script.size(), row(KIND_ARRIVE, '0, 1'b0, '0, STATUS_SERVED));
        script.insert(script.size(), row(KIND_ARRIVE, 20'h12345, 1'b0, '0, STATUS_SERVED));
        script.insert(script.size(), row(KIND_ARRIVE, 20'h12345, 1'b0, '0, STATUS_SERVED));
        script.insert(script.size(), row(KIND_ARRIVE, VALUE_MAX, 1'b0, '0, STATUS_SERVED));
        script.insert(script.size(), row(KIND_BEST, '0, 1'b0, '0, STATUS_SERVED));
        script.insert(script.size(), row(KIND_BEST, 20'hAAAAA, 1'b0, '0, STATUS_SERVED));
        script.insert(script.size(), row(KIND_OLDEST, 20'h55555, 1'b0, '0, STATUS_SERVED));
        script.insert(script.size(), row(KIND_BEST, '0, 1'b0, '0, STATUS_SERVED));
        script.insert(script.size(), row(KIND_OLDEST, '0, 1'b0, '0, STATUS_SERVED));
        script.insert(script.size(), row(KIND_OLDEST, '0, 1'b0, '0, STATUS_SERVED));
        script.insert(script.size(), row(KIND_BEST, '0, 1'b0, '0, STATUS_SERVED));
        script.insert(script.size(), row(KIND_ARRIVE, 20'd7, 1'b0, '0, STATUS_SERVED));
        script.insert(script.size(), row(KIND_ARRIVE, 20'd9, 1'b0, '0, STATUS_SERVED));
        script.insert(script.size(), row(KIND_UNUSED, 20'h55555, 1'b0, '0, STATUS_SERVED));
        script.insert(script.size(), row(KIND_OLDEST, '0, 1'b0, '0, STATUS_SERVED));
        script.insert(script.size(), row(KIND_BEST, '0, 1'b0, '0, STATUS_SERVED));
        script.insert(script.size(), row(KIND_BEST, '0, 1'b0, '0, STATUS_SERVED));
        script.insert(script.size(), row(KIND_ARRIVE, 20'h80000, 1'b0, '0, STATUS_SERVED));
        script.insert(script.size(), row(KIND_ARRIVE, 20'd1, 1'b0, '0, STATUS_SERVED));
        script.insert(script.size(), row(KIND_BEST, '0, 1'b0, '0, STATUS_SERVED));
        script.insert(script.size(), row(KIND_OLDEST, '0, 1'b0, '0, STATUS_SERVED));

        foreach (script[i])
        begin
            transfer_request(script[i].kind, script[i].value, script[i].fixed, script[i].want);
            sender_pace();
        end
        drain_expected();

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS / 2)
                drain_expected();
            random_request();
        end
        drain_expected();

        while (waiting_count > 0)
            serve_request();
        for (int n = 0; n < 6; n++)
            random_request();

        drain_expected();
        repeat (64) @(posedge clk);
        if (mismatch_count == 0 && pending_services.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
